// File: rtl/core/cowr_pkg.sv
// ----------------------------------------------------------------------------
// cowr_pkg: shared types and constants of the overlay router
// Field widths, result kinds, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cowr_pkg;

  localparam int SECT_W = 23;
  localparam int LOG_W  = 24;
  localparam int CNT_W  = 8;
  localparam int LEN_W  = 8;
  localparam int KIND_W = 3;

  localparam logic [LOG_W-1:0] LOG_RESET = 24'd8388608;

  typedef enum logic [KIND_W-1:0] {
    KIND_RD_OVL    = 3'd0,
    KIND_RD_BASE   = 3'd1,
    KIND_COPY      = 3'd2,
    KIND_WR_OVL    = 3'd3,
    KIND_RANGE_ERR = 3'd4
  } chunk_kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_DIV_FIX,
    ST_LOOKUP,
    ST_ROUTE,
    ST_WRITE
  } cowr_state_e;

  typedef struct packed {
    logic clr_en;
    logic load_req;
    logic div_fix;
    logic emit_err;
    logic emit_copy;
    logic emit_chunk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic range_err;
    logic present;
    logic is_write;
    logic fin;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/cowr_if.sv
// ----------------------------------------------------------------------------
// cowr_if: request and chunk channel interfaces
// Valid/ready channels; one transfer at each edge with valid and ready high.
// ----------------------------------------------------------------------------
interface cowr_req_if import cowr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SECT_W-1:0] start_sector;
  logic [CNT_W-1:0]  sector_count;

  modport source (output valid, func, start_sector, sector_count, input ready);
  modport sink   (input valid, func, start_sector, sector_count, output ready);
endinterface

interface cowr_chunk_if import cowr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] chunk_kind;
  logic [SECT_W-1:0] chunk_sector;
  logic [LEN_W-1:0]  chunk_length;
  logic              last;

  modport source (output valid, chunk_kind, chunk_sector, chunk_length, last,
                  input ready);
  modport sink   (input valid, chunk_kind, chunk_sector, chunk_length, last,
                  output ready);
endinterface

// File: rtl/core/cowr_ctrl.sv
// ----------------------------------------------------------------------------
// cowr_ctrl: overlay router controller
// Sequences map clearing, request check, block index setup and chunk emission.
// ----------------------------------------------------------------------------
module cowr_ctrl import cowr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dp_status_t  status_i,
  output ctrl_cmd_t   cmd_o
);

  cowr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.empty) begin
          state_d = ST_IDLE;
        end else if (status_i.range_err) begin
          if (status_i.out_free) begin
            cmd_o.emit_err = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: state_d = ST_DIV_FIX;
      ST_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_ROUTE;
      ST_ROUTE: begin
        if (status_i.out_free) begin
          if (status_i.is_write && !status_i.present) begin
            cmd_o.emit_copy = 1'b1;
            state_d         = ST_WRITE;
          end else begin
            cmd_o.emit_chunk = 1'b1;
            state_d          = status_i.fin ? ST_IDLE : ST_LOOKUP;
          end
        end
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.emit_chunk = 1'b1;
          state_d          = status_i.fin ? ST_IDLE : ST_LOOKUP;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

// File: rtl/core/cowr_dp.sv
// ----------------------------------------------------------------------------
// cowr_dp: overlay router datapath
// Size register, request registers, block index by reciprocal multiply,
// chunk arithmetic, presence map memory and the output register.
// ----------------------------------------------------------------------------
module cowr_dp import cowr_pkg::*; #(
  parameter int BLOCK_SECTORS   = 8,
  parameter int MAX_BLOCKS      = 1048576,
  parameter int MAX_REQ_SECTORS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LOG_W-1:0]  cfg_wdata_i,
  input  logic              in_func_i,
  input  logic [SECT_W-1:0] in_start_i,
  input  logic [CNT_W-1:0]  in_count_i,
  input  logic              out_ready_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  output logic              out_valid_o,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [SECT_W-1:0] out_sector_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic              out_last_o
);

  localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int RECIP_SHIFT = SECT_W + 1;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int BW          = 9;
  localparam int LIM_W       = 34;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'(1) << RECIP_SHIFT) / 64'(BLOCK_SECTORS));
  localparam logic [LIM_W-1:0] LIMIT =
    LIM_W'(64'(MAX_BLOCKS) * 64'(BLOCK_SECTORS));
  localparam logic [BW-1:0]    BLK_B    = BW'(BLOCK_SECTORS);
  localparam logic [LOG_W-1:0] BLK_SECT = LOG_W'(BLOCK_SECTORS);
  localparam logic [CNT_W:0]   MAX_REQ  = (CNT_W+1)'(MAX_REQ_SECTORS);
  localparam logic [BLK_W-1:0] CLR_LAST = BLK_W'(MAX_BLOCKS - 1);

  logic [LOG_W-1:0]  logical_q;
  logic              func_q;
  logic [SECT_W-1:0] start_q;
  logic [CNT_W-1:0]  count_q;
  logic [LOG_W-1:0]  qest_q, qb_q;
  logic [LOG_W-1:0]  cur_q, bstart_q;
  logic [BLK_W-1:0]  blk_q, clr_q;
  logic              present_q;
  logic              map_mem [MAX_BLOCKS];

  logic              out_valid_q, out_last_q;
  chunk_kind_e       out_kind_q;
  logic [SECT_W-1:0] out_sector_q;
  logic [LEN_W-1:0]  out_length_q;

  logic [SECT_W+RECIP_W-1:0] prod;
  logic [LOG_W+BW-1:0]       qb_full;
  logic [LOG_W-1:0]          start_ext, rem, q_fix, bstart_fix, end_sum;
  logic [LOG_W-1:0]          diff, bsize, blk_end, len_a, len_b, len;
  logic                      fix_up, fin, out_free, range_err;
  chunk_kind_e               chunk_kind;

  assign start_ext  = LOG_W'(start_q);
  assign prod       = SECT_W'(start_q) * RECIP;
  assign qb_full    = qest_q * BLK_B;
  assign rem        = start_ext - qb_q;
  assign fix_up     = rem >= BLK_SECT;
  assign q_fix      = fix_up ? qest_q + LOG_W'(1) : qest_q;
  assign bstart_fix = fix_up ? qb_q + BLK_SECT : qb_q;
  assign end_sum    = start_ext + LOG_W'(count_q);
  assign range_err  = ({1'b0, count_q} > MAX_REQ) || (end_sum > logical_q) ||
                      (LIM_W'(end_sum) > LIMIT);

  assign diff    = logical_q - bstart_q;
  assign bsize   = (diff > BLK_SECT) ? BLK_SECT : diff;
  assign blk_end = bstart_q + bsize;
  assign len_a   = blk_end - cur_q;
  assign len_b   = end_sum - cur_q;
  assign fin     = len_a >= len_b;
  assign len     = fin ? len_b : len_a;

  assign chunk_kind = func_q ? KIND_WR_OVL : (present_q ? KIND_RD_OVL : KIND_RD_BASE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logical_q <= LOG_RESET;
    end else if (cfg_we_i) begin
      logical_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + BLK_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q  <= in_func_i;
      start_q <= in_start_i;
      count_q <= in_count_i;
    end
    qest_q <= LOG_W'(prod >> RECIP_SHIFT);
    qb_q   <= qb_full[LOG_W-1:0];
    if (cmd_i.div_fix) begin
      cur_q    <= start_ext;
      bstart_q <= bstart_fix;
      blk_q    <= q_fix[BLK_W-1:0];
    end else if (cmd_i.emit_chunk) begin
      cur_q    <= blk_end;
      bstart_q <= bstart_q + BLK_SECT;
      blk_q    <= blk_q + BLK_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      map_mem[clr_q] <= 1'b0;
    end else if (cmd_i.emit_copy) begin
      map_mem[blk_q] <= 1'b1;
    end
    present_q <= map_mem[blk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_err || cmd_i.emit_copy || cmd_i.emit_chunk) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_kind_q   <= KIND_RANGE_ERR;
      out_sector_q <= start_q;
      out_length_q <= count_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_copy) begin
      out_kind_q   <= KIND_COPY;
      out_sector_q <= bstart_q[SECT_W-1:0];
      out_length_q <= bsize[LEN_W-1:0];
      out_last_q   <= 1'b0;
    end else if (cmd_i.emit_chunk) begin
      out_kind_q   <= chunk_kind;
      out_sector_q <= cur_q[SECT_W-1:0];
      out_length_q <= len[LEN_W-1:0];
      out_last_q   <= fin;
    end
  end

  assign status_o.clr_done  = clr_q == CLR_LAST;
  assign status_o.empty     = count_q == '0;
  assign status_o.range_err = range_err;
  assign status_o.present   = present_q;
  assign status_o.is_write  = func_q;
  assign status_o.fin       = fin;
  assign status_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_sector_o = out_sector_q;
  assign out_length_o = out_length_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/core/copy_on_write_overlay_router_top.sv
// ----------------------------------------------------------------------------
// copy_on_write_overlay_router_top: copy-on-write overlay request router
// Splits sector requests at overlay-block boundaries and routes each chunk.
// ----------------------------------------------------------------------------
// Usage:
//   req_i is a valid/ready request channel (func, start_sector, sector_count).
//   chunk_o is a valid/ready result channel (chunk_kind, chunk_sector,
//   chunk_length, last); last marks the final result of a request.
//   cfg_we_i/cfg_wdata_i write the logical disk size in sectors; write only
//   while no request is in flight.
//   One request is in work at a time. After acceptance: a range check state,
//   then block index setup (two registered multiplies and a correction), then
//   lookup and route states per block chunk, plus a write state when a block
//   copy precedes an overlay write. A range error result is loaded into the
//   output register from the range check; an empty request gives no result.
//   The chunk loop, bound by the registered presence map read, sets the rate.
//   After reset the presence map is cleared one block per cycle, all MAX_BLOCKS
//   blocks, with req_i.ready low; the size register resets to 8388608.
//   A stalled chunk_o holds its result; work stops only when a new result
//   is ready and the output register is still occupied. The next request is
//   accepted while the final result of the previous one still waits.
// ----------------------------------------------------------------------------
module copy_on_write_overlay_router_top import cowr_pkg::*; #(
  parameter int BLOCK_SECTORS   = 8,
  parameter int MAX_BLOCKS      = 1048576,
  parameter int MAX_REQ_SECTORS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LOG_W-1:0]   cfg_wdata_i,
  cowr_req_if.sink           req_i,
  cowr_chunk_if.source       chunk_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cowr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cowr_dp #(
    .BLOCK_SECTORS   (BLOCK_SECTORS),
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_REQ_SECTORS (MAX_REQ_SECTORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_func_i    (req_i.func),
    .in_start_i   (req_i.start_sector),
    .in_count_i   (req_i.sector_count),
    .out_ready_i  (chunk_o.ready),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (chunk_o.valid),
    .out_kind_o   (chunk_o.chunk_kind),
    .out_sector_o (chunk_o.chunk_sector),
    .out_length_o (chunk_o.chunk_length),
    .out_last_o   (chunk_o.last)
  );

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> (!chunk_o.valid && !req_i.ready))
    else $error("transfer activity during map clear");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_err || cmd.emit_copy || cmd.emit_chunk) |-> status.out_free)
    else $error("output register overwritten");

  a_copy_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_copy |-> (status.is_write && !status.present))
    else $error("block copy for present block or read");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chunk_o.valid && chunk_o.chunk_kind == KIND_RANGE_ERR) |-> chunk_o.last)
    else $error("range error not final");

endmodule

// File: tb/tb_copy_on_write_overlay_router_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_copy_on_write_overlay_router_top: request routing and block copy check
// Drives read and write sector requests under several disk sizes. Each
// accepted request is split into expected chunks against a local copy of the
// block presence map, and every chunk transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_copy_on_write_overlay_router_top;
  import cowr_pkg::*;

  localparam int unsigned BLK_SECTORS   = 8;
  localparam int unsigned NUM_BLOCKS    = 1048576;
  localparam int unsigned MAX_REQ       = 128;
  localparam int unsigned SECT_MAX      = 8388607;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          HOLD_CYCLES   = 120;
  localparam int          CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    logic              func;
    logic [SECT_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } sector_req_t;

  typedef struct {
    chunk_kind_e       kind;
    logic [SECT_W-1:0] sector;
    logic [LEN_W-1:0]  length;
    logic              last;
  } chunk_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LOG_W-1:0] cfg_wdata_i;

  cowr_req_if   req_if ();
  cowr_chunk_if chunk_if ();

  copy_on_write_overlay_router_top #(
    .BLOCK_SECTORS  (BLK_SECTORS),
    .MAX_BLOCKS     (NUM_BLOCKS),
    .MAX_REQ_SECTORS(MAX_REQ)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .chunk_o    (chunk_if)
  );

  sector_req_t      req_backlog[$];
  chunk_t           pending_chunks[$];
  bit               present_map [NUM_BLOCKS];
  logic [LOG_W-1:0] disk_size = LOG_RESET;

  sector_req_t nxt_req;
  chunk_t      want;
  logic        req_taken = 1'b0;
  logic        hold_off  = 1'b0;
  logic        idle_on   = 1'b1;
  int          send_gap  = 0;
  int          stall_left = 0;
  int          cycles    = 0;
  int          n_fail    = 0;
  int          n_reqs    = 0;
  int          n_chunks  = 0;
  int          n_copies  = 0;
  int          n_range   = 0;
  int          n_sizes   = 1;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void add_chunk(input chunk_kind_e kind, input longint unsigned sector,
                                    input longint unsigned length, input bit last);
    chunk_t c;
    c.kind   = kind;
    c.sector = sector[SECT_W-1:0];
    c.length = length[LEN_W-1:0];
    c.last   = last;
    pending_chunks.push_back(c);
  endfunction

  function automatic void split_request(input logic wr, input logic [SECT_W-1:0] start,
                                        input logic [CNT_W-1:0] count);
    longint unsigned first, cnt, stop, cur, blk, bstart, bsize, len;
    first = start;
    cnt   = count;
    stop  = first + cnt;
    if (cnt == 0) return;
    if (cnt > MAX_REQ || stop > disk_size ||
        stop > longint'(NUM_BLOCKS) * BLK_SECTORS) begin
      add_chunk(KIND_RANGE_ERR, first, cnt, 1'b1);
      return;
    end
    cur = first;
    while (cur < stop) begin
      blk    = cur / BLK_SECTORS;
      bstart = blk * BLK_SECTORS;
      bsize  = disk_size - bstart;
      if (bsize > BLK_SECTORS) bsize = BLK_SECTORS;
      len = bstart + bsize - cur;
      if (len > stop - cur) len = stop - cur;
      if (wr) begin
        if (!present_map[blk]) begin
          add_chunk(KIND_COPY, bstart, bsize, 1'b0);
          present_map[blk] = 1'b1;
        end
        add_chunk(KIND_WR_OVL, cur, len, cur + len >= stop);
      end else begin
        add_chunk(present_map[blk] ? KIND_RD_OVL : KIND_RD_BASE, cur, len, cur + len >= stop);
      end
      cur += len;
    end
  endfunction

  function automatic void add_req(input logic func, input int unsigned start,
                                  input int unsigned count);
    sector_req_t r;
    r.func  = func;
    r.start = start[SECT_W-1:0];
    r.count = count[CNT_W-1:0];
    req_backlog.push_back(r);
  endfunction

  task automatic settle();
    while (req_backlog.size() != 0 || req_if.valid || pending_chunks.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_disk_size(input logic [LOG_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    disk_size    = value;
    n_sizes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_random(input int n, input int unsigned lo, input int unsigned hi);
    int unsigned sel, s, c;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) s = $urandom_range(0, SECT_MAX);
      else if (sel == 1) s = (disk_size > 140) ? disk_size - $urandom_range(0, 140)
                                               : $urandom_range(0, 140);
      else s = $urandom_range(lo, hi);
      if (s > SECT_MAX) s = SECT_MAX;
      sel = $urandom_range(0, 19);
      if (sel < 14) c = $urandom_range(1, 40);
      else if (sel < 17) c = $urandom_range(41, 128);
      else if (sel == 17) c = 0;
      else c = $urandom_range(129, 255);
      add_req(1'($urandom_range(0, 1)), s, c);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        nxt_req = req_backlog.pop_front();
        req_if.func         <= nxt_req.func;
        req_if.start_sector <= nxt_req.start;
        req_if.sector_count <= nxt_req.count;
        req_if.valid        <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // chunk receiver
  always @(negedge clk_i) begin
    if (hold_off) begin
      chunk_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      chunk_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      chunk_if.ready <= 1'b0;
    end else begin
      chunk_if.ready <= 1'b1;
    end
  end

  // hold off the receiver so the block backs up into the request channel
  initial begin
    while (n_reqs < 30) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (chunk_if.valid && chunk_if.ready) begin
        n_chunks++;
        if (pending_chunks.size() == 0) begin
          $error("unexpected chunk: kind %0d sector %0d length %0d last %0d",
                 chunk_if.chunk_kind, chunk_if.chunk_sector, chunk_if.chunk_length,
                 chunk_if.last);
          n_fail++;
        end else begin
          want = pending_chunks.pop_front();
          if (chunk_if.chunk_kind !== want.kind) begin
            $error("chunk_kind: expected %0d, got %0d", want.kind, chunk_if.chunk_kind);
            n_fail++;
          end
          if (chunk_if.chunk_sector !== want.sector) begin
            $error("chunk_sector: expected %0d, got %0d", want.sector, chunk_if.chunk_sector);
            n_fail++;
          end
          if (chunk_if.chunk_length !== want.length) begin
            $error("chunk_length: expected %0d, got %0d", want.length, chunk_if.chunk_length);
            n_fail++;
          end
          if (chunk_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, chunk_if.last);
            n_fail++;
          end
          if (want.kind == KIND_COPY) n_copies++;
          if (want.kind == KIND_RANGE_ERR) n_range++;
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_reqs++;
        split_request(req_if.func, req_if.start_sector, req_if.sector_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chunks still expected", cycles,
               pending_chunks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sz;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.func         = 1'b0;
    req_if.start_sector = '0;
    req_if.sector_count = '0;
    chunk_if.ready      = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_req(1'b0, 0, 1);
    add_req(1'b1, 0, 1);
    add_req(1'b0, 0, 8);
    add_req(1'b1, 5, 10);
    add_req(1'b0, 0, 128);
    add_req(1'b1, 4099, 128);
    add_req(1'b0, 20, 0);
    add_req(1'b1, 20, 0);
    add_req(1'b0, 100, 129);
    add_req(1'b1, 100, 255);
    add_req(1'b0, SECT_MAX, 1);
    add_req(1'b1, 8388600, 8);
    add_req(1'b0, SECT_MAX, 2);
    add_req(1'b1, SECT_MAX, 255);

    set_disk_size(24'd1003);
    add_req(1'b0, 990, 13);
    add_req(1'b1, 1000, 3);
    add_req(1'b1, 1001, 3);

    set_disk_size(24'd1);
    add_req(1'b0, 0, 1);
    add_req(1'b1, 0, 1);
    add_req(1'b0, 0, 2);

    set_disk_size(24'd0);
    add_req(1'b0, 0, 1);
    add_req(1'b1, 0, 0);

    set_disk_size(24'hFFFFFF);
    add_req(1'b1, 8388592, 16);
    add_req(1'b0, SECT_MAX, 2);

    set_disk_size(LOG_RESET);
    queue_random(20, 0, 511);
    // pause the sender until the block has drained
    settle();
    queue_random(20, 0, 511);

    sz = $urandom_range(2000, 6000);
    set_disk_size(sz[LOG_W-1:0]);
    queue_random(40, sz - 600, sz - 1);

    sz = $urandom_range(8388000, 16777215);
    set_disk_size(sz[LOG_W-1:0]);
    queue_random(40, 8387000, SECT_MAX);

    settle();
    idle_on = 1'b0;
    set_disk_size(24'd4093);
    queue_random(40, 3500, 4092);

    settle();
    $display("%0d requests over %0d disk sizes gave %0d chunks", n_reqs, n_sizes, n_chunks);
    $display("including %0d block copies and %0d range errors", n_copies, n_range);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cowr_pkg.sv
rtl/core/cowr_if.sv
rtl/core/cowr_ctrl.sv
rtl/core/cowr_dp.sv
rtl/core/copy_on_write_overlay_router_top.sv
tb/tb_copy_on_write_overlay_router_top.sv
